[rtl/core/rpn_stack_calculator_defines.svh]
// Assertion macros for the RPN stack calculator checker.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// same-cycle implication
`define RPN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpn_stack_calculator: same-cycle check failed");

// next-cycle implication
`define RPN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpn_stack_calculator: next-cycle check failed");

`endif

[rtl/core/rpn_pkg.sv]
// Shared types, widths and codes for the RPN stack calculator.
// No dependencies.
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int OPERAND_W   = 31;
  localparam int ACTION_W    = 3;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_W     = 5;
  localparam int ITER_W      = $clog2(DATA_W);

  typedef logic [ACTION_W-1:0]  action_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [OPERAND_W-1:0] operand_t;
  typedef logic [DEPTH_W-1:0]   depth_t;

  localparam action_t ACT_PUSH   = 3'd0;
  localparam action_t ACT_ADD    = 3'd1;
  localparam action_t ACT_SUB    = 3'd2;
  localparam action_t ACT_MUL    = 3'd3;
  localparam action_t ACT_DIV    = 3'd4;
  localparam action_t ACT_FINISH = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_UNDER = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_DIVZ  = 2'd3;

endpackage

[rtl/core/rpn_stack_calculator.sv]
// RPN stack calculator: token sequencer, stack memory and one shared adder
// used for add, subtract, shift-add multiply and restoring divide.
// Depends on rpn_pkg.
//
//   channel  direction  ports
//   in       input      in_valid, in_ready, in_action, in_operand
//   out      output     out_valid, out_ready, out_top_value, out_status, out_depth
//
// Push and unused codes go from idle straight to the output state. Finish:
// one pop, then output. Add/subtract: two pops, execute, push. Divide: 32
// steps of the shared 33-bit adder, one bit per cycle, unless dividing by zero.
// Stack pops go through the single registered read port, one pop per cycle.
// rst_n (synchronous) empties the stack; entries are not cleared.
// One token at a time; a result held by a stalled output delays only the
// next token's final write to the output register.
module rpn_stack_calculator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rpn_pkg::action_t  in_action,
  input  rpn_pkg::operand_t in_operand,
  output logic              out_valid,
  input  logic              out_ready,
  output rpn_pkg::data_t    out_top_value,
  output rpn_pkg::status_t  out_status,
  output rpn_pkg::depth_t   out_depth
);
  import rpn_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POP_R = 4'd1;
  localparam logic [3:0] S_POP_L = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_ABS_N = 4'd5;
  localparam logic [3:0] S_ABS_D = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_SIGN  = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, count_dec;
  action_t          op_r, op_nxt;
  logic             empty_r, empty_nxt;
  logic             under_r, under_nxt;
  logic             divz_r, divz_nxt;
  logic             neg_r, neg_nxt;
  data_t            l_r, l_nxt;
  data_t            r_r, r_nxt;
  data_t            acc_r, acc_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  data_t            res_val_r, res_val_nxt;
  status_t          res_status_r, res_status_nxt;
  logic             out_valid_r, out_valid_nxt;
  data_t            out_val_r, out_val_nxt;
  status_t          out_status_r, out_status_nxt;
  depth_t           out_depth_r, out_depth_nxt;

  data_t            stack_mem [STACK_DEPTH];
  data_t            rd_data_r;
  logic             rd_en, wr_en, pop_req;
  logic [PTR_W-1:0] rd_addr, wr_addr;
  data_t            wr_data, pop_val;

  logic [DATA_W:0]   add_a, add_b;
  logic              add_sub;
  logic [DATA_W+1:0] add_sum;
  logic              last_iter, stack_full;

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_top_value = out_val_r;
  assign out_status    = out_status_r;
  assign out_depth     = out_depth_r;

  assign count_dec  = count_r - 1'b1;
  assign stack_full = (count_r >= CNT_W'(STACK_DEPTH));
  assign last_iter  = (cnt_r == ITER_W'(DATA_W - 1));
  assign pop_val    = empty_r ? '1 : rd_data_r;

  // shared adder operand select
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_r)
      S_EXEC: begin
        add_a   = {1'b0, l_r};
        add_b   = {1'b0, r_r};
        add_sub = (op_r == ACT_SUB);
      end
      S_MUL: begin
        add_a = {1'b0, acc_r};
        add_b = r_r[0] ? {1'b0, l_r} : '0;
      end
      S_ABS_N: begin
        add_b   = {1'b0, l_r};
        add_sub = l_r[DATA_W-1];
      end
      S_ABS_D: begin
        add_b   = {1'b0, r_r};
        add_sub = r_r[DATA_W-1];
      end
      S_DIV: begin
        add_a   = {acc_r, l_r[DATA_W-1]};
        add_b   = {1'b0, r_r};
        add_sub = 1'b1;
      end
      S_SIGN: begin
        add_b   = {1'b0, l_r};
        add_sub = neg_r;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {(DATA_W+1){add_sub}}}
                 + (DATA_W+2)'(add_sub);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    empty_nxt      = empty_r;
    under_nxt      = under_r;
    divz_nxt       = divz_r;
    neg_nxt        = neg_r;
    l_nxt          = l_r;
    r_nxt          = r_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    res_val_nxt    = res_val_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_val_nxt    = out_val_r;
    out_status_nxt = out_status_r;
    out_depth_nxt  = out_depth_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[PTR_W-1:0];
    wr_data        = res_val_r;
    pop_req        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_action;
          under_nxt = 1'b0;
          divz_nxt  = 1'b0;
          case (in_action)
            ACT_PUSH: begin
              res_val_nxt = {1'b0, in_operand};
              if (stack_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en          = 1'b1;
                wr_data        = {1'b0, in_operand};
                count_nxt      = count_r + 1'b1;
                res_status_nxt = ST_OK;
              end
              state_nxt = S_OUT;
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_FINISH: begin
              pop_req   = 1'b1;
              state_nxt = S_POP_R;
            end
            default: begin
              res_val_nxt    = '0;
              res_status_nxt = ST_OK;
              state_nxt      = S_OUT;
            end
          endcase
        end
      end
      S_POP_R: begin
        if (op_r == ACT_FINISH) begin
          res_val_nxt    = pop_val;
          res_status_nxt = under_r ? ST_UNDER : ST_OK;
          state_nxt      = S_OUT;
        end else begin
          r_nxt     = pop_val;
          pop_req   = 1'b1;
          state_nxt = S_POP_L;
        end
      end
      S_POP_L: begin
        l_nxt     = pop_val;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cnt_nxt = '0;
        case (op_r)
          ACT_ADD, ACT_SUB: begin
            res_val_nxt = add_sum[DATA_W-1:0];
            state_nxt   = S_PUSH;
          end
          ACT_MUL: begin
            acc_nxt   = '0;
            state_nxt = S_MUL;
          end
          ACT_DIV: begin
            if (r_r == '0) begin
              res_val_nxt = '0;
              divz_nxt    = 1'b1;
              state_nxt   = S_PUSH;
            end else begin
              neg_nxt   = l_r[DATA_W-1] ^ r_r[DATA_W-1];
              state_nxt = S_ABS_N;
            end
          end
          default: begin
            res_val_nxt = '0;
            state_nxt   = S_PUSH;
          end
        endcase
      end
      S_MUL: begin
        acc_nxt = add_sum[DATA_W-1:0];
        l_nxt   = {l_r[DATA_W-2:0], 1'b0};
        r_nxt   = {1'b0, r_r[DATA_W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (last_iter) begin
          res_val_nxt = add_sum[DATA_W-1:0];
          state_nxt   = S_PUSH;
        end
      end
      S_ABS_N: begin
        l_nxt     = add_sum[DATA_W-1:0];
        acc_nxt   = '0;
        state_nxt = S_ABS_D;
      end
      S_ABS_D: begin
        r_nxt     = add_sum[DATA_W-1:0];
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // carry out set: trial subtract did not borrow
        if (add_sum[DATA_W+1]) begin
          acc_nxt = add_sum[DATA_W-1:0];
        end else begin
          acc_nxt = {acc_r[DATA_W-2:0], l_r[DATA_W-1]};
        end
        l_nxt   = {l_r[DATA_W-2:0], add_sum[DATA_W+1]};
        cnt_nxt = cnt_r + 1'b1;
        if (last_iter) begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        res_val_nxt = add_sum[DATA_W-1:0];
        state_nxt   = S_PUSH;
      end
      S_PUSH: begin
        if (!stack_full) begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
        res_status_nxt = divz_r ? ST_DIVZ : (under_r ? ST_UNDER : ST_OK);
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_val_nxt    = res_val_r;
          out_status_nxt = res_status_r;
          out_depth_nxt  = DEPTH_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // pop through the registered read port
    rd_en   = 1'b0;
    rd_addr = count_dec[PTR_W-1:0];
    if (pop_req) begin
      if (count_r != '0) begin
        rd_en     = 1'b1;
        count_nxt = count_dec;
        empty_nxt = 1'b0;
      end else begin
        empty_nxt = 1'b1;
        under_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    empty_r      <= empty_nxt;
    under_r      <= under_nxt;
    divz_r       <= divz_nxt;
    neg_r        <= neg_nxt;
    l_r          <= l_nxt;
    r_r          <= r_nxt;
    acc_r        <= acc_nxt;
    cnt_r        <= cnt_nxt;
    res_val_r    <= res_val_nxt;
    res_status_r <= res_status_nxt;
    out_val_r    <= out_val_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
  end

endmodule

[rtl/core/rpn_checker.sv]
// Port-level assertions for the RPN stack calculator, bound to the top level.
// Depends on rpn_pkg and rpn_stack_calculator_defines.svh.
`include "rpn_stack_calculator_defines.svh"

module rpn_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input rpn_pkg::action_t  in_action,
  input rpn_pkg::operand_t in_operand,
  input logic              out_valid,
  input logic              out_ready,
  input rpn_pkg::data_t    out_top_value,
  input rpn_pkg::status_t  out_status,
  input rpn_pkg::depth_t   out_depth
);
  import rpn_pkg::*;

  logic in_fire;
  logic unused_ok;

  assign in_fire   = in_valid && in_ready;
  assign unused_ok = ^{in_action, in_operand};

  `RPN_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready)
  `RPN_ASSERT_IMP(a_full_depth, out_valid && (out_status == ST_FULL), out_depth == DEPTH_W'(STACK_DEPTH))
  `RPN_ASSERT_IMP(a_under_depth, out_valid && (out_status == ST_UNDER), (out_depth == 5'd0) || (out_depth == 5'd1))
  `RPN_ASSERT_IMP(a_divz_zero, out_valid && (out_status == ST_DIVZ) && (unused_ok || !unused_ok), out_top_value == '0)
  `RPN_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_top_value))

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (.*);
